>>> rtl/core/mtg_pkg.sv
package mtg_pkg;

  localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam int unsigned SHIFT_M      = 397;
  localparam int unsigned INIT_SHIFT   = 30;

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  typedef enum logic [2:0] {
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_IDLE,
    ST_DRAW_OUT,
    ST_TW_PRIME,
    ST_TW_RD,
    ST_TW_WR
  } mtg_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } mtg_result_t;

endpackage

>>> rtl/core/mtg_table_ram.sv
module mtg_table_ram #(
  parameter int DEPTH  = 624,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/mtg_sequencer.sv
module mtg_sequencer #(
  parameter int TABLE_LENGTH = 624,
  parameter int IDX_W        = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [31:0]         in_seed,
  input  logic                out_free,
  output mtg_pkg::mtg_result_t result,
  output logic                ram_we,
  output logic [IDX_W-1:0]    ram_waddr,
  output logic [31:0]         ram_wdata,
  output logic [IDX_W-1:0]    ram_raddr_a,
  output logic [IDX_W-1:0]    ram_raddr_b,
  input  logic [31:0]         ram_rdata_a,
  input  logic [31:0]         ram_rdata_b
);
  import mtg_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_LENGTH - 1);
  localparam logic [IDX_W:0]   TAB_LEN  = (IDX_W+1)'(TABLE_LENGTH);
  localparam logic [IDX_W:0]   SHIFT_W  = (IDX_W+1)'(SHIFT_M);

  mtg_state_t       state, state_next;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic [31:0]      prev;
  logic [31:0]      prod;
  logic [31:0]      cur;

  logic             accept;
  logic             pos_last;
  logic             idx_last;
  logic [IDX_W-1:0] pos_succ;
  logic [IDX_W:0]   far_sum;
  logic [IDX_W-1:0] far_pos;
  logic [31:0]      seed_word;
  logic [31:0]      mix;
  logic [31:0]      twist_word;
  logic [31:0]      scrambled;

  assign accept    = in_valid && in_ready;
  assign pos_last  = (pos == LAST_IDX);
  assign idx_last  = (idx == LAST_IDX);
  assign pos_succ  = pos_last ? '0 : pos + 1'b1;
  assign far_sum   = {1'b0, pos} + SHIFT_W;
  assign far_pos   = (far_sum >= TAB_LEN) ? IDX_W'(far_sum - TAB_LEN) : far_sum[IDX_W-1:0];
  assign seed_word = (pos == '0) ? prev : prod + {{(32-IDX_W){1'b0}}, pos};
  assign mix       = (cur & UPPER_MASK) | (ram_rdata_a & LOWER_MASK);
  assign twist_word = ram_rdata_b ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : 32'h0);
  assign scrambled = prev ^ (prev >> INIT_SHIFT);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SEED_MUL: state_next = ST_SEED_WR;
      ST_SEED_WR:  state_next = pos_last ? ST_IDLE : ST_SEED_MUL;
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_opcode == OP_DRAW) ? ST_DRAW_OUT : ST_SEED_WR;
        end
      end
      ST_DRAW_OUT: begin
        if (out_free) begin
          state_next = idx_last ? ST_TW_PRIME : ST_IDLE;
        end
      end
      ST_TW_PRIME: state_next = ST_TW_RD;
      ST_TW_RD:    state_next = ST_TW_WR;
      ST_TW_WR:    state_next = pos_last ? ST_IDLE : ST_TW_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos;
    ram_wdata    = twist_word;
    ram_raddr_a  = idx;
    ram_raddr_b  = far_pos;
    result.valid = 1'b0;
    result.word  = ram_rdata_a;
    unique case (state)
      ST_SEED_WR: begin
        ram_we    = 1'b1;
        ram_wdata = seed_word;
      end
      ST_IDLE:     in_ready = 1'b1;
      ST_DRAW_OUT: result.valid = out_free;
      ST_TW_PRIME: ram_raddr_a = '0;
      ST_TW_RD:    ram_raddr_a = pos_succ;
      ST_TW_WR:    ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEED_WR;
      pos   <= '0;
      idx   <= '0;
      prev  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_SEED_MUL: prod <= INIT_MULT * scrambled;
        ST_SEED_WR: begin
          prev <= seed_word;
          pos  <= pos_succ;
          idx  <= '0;
        end
        ST_IDLE: begin
          if (accept && in_opcode == OP_RESEED) begin
            prev <= in_seed;
            pos  <= '0;
          end
        end
        ST_DRAW_OUT: begin
          if (out_free) begin
            idx <= idx_last ? '0 : idx + 1'b1;
          end
        end
        ST_TW_PRIME: pos <= '0;
        ST_TW_RD: begin
          if (pos == '0) begin
            cur <= ram_rdata_a;
          end
        end
        ST_TW_WR: begin
          cur <= ram_rdata_a;
          pos <= pos_succ;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/mersenne_twister_generator_top.sv
// untempered mt19937-style word generator over a table of TABLE_LENGTH words
// input channel s_*: s_tuser is the opcode (0 reseed, 1 draw), s_tdata the seed
// output channel m_*: one 32-bit word per draw, none per reseed
// a transfer is taken only while the sequencer is idle (s_tready high)
// draw: the word is loaded into the output register from ST_DRAW_OUT once that
// register is free, and only then can a new transfer be taken
// the draw that takes the last table word starts a twist of the whole table
// with s_tready low: two table reads and one write per word
// reseed: s_tready stays low while the table is refilled, with one write per
// table word and one multiply for each word after the first
// after reset the table is filled from seed zero, with s_tready low during that fill
// when m_tready is low the word waits in the output register; a further draw
// can be taken and holds in the sequencer until the register frees up
// reseeds are taken while a word waits
module mersenne_twister_generator_top #(
  parameter int TABLE_LENGTH = 624
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // opcode
  input  logic [31:0] s_tdata,   // seed_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // random_word
);
  import mtg_pkg::*;

  localparam int IDX_W = $clog2(TABLE_LENGTH);

  mtg_result_t      result;
  logic             out_free;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr_a;
  logic [IDX_W-1:0] ram_raddr_b;
  logic [31:0]      ram_rdata_a;
  logic [31:0]      ram_rdata_b;

  assign out_free = !m_tvalid || m_tready;

  mtg_sequencer #(
    .TABLE_LENGTH(TABLE_LENGTH),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_opcode  (s_tuser),
    .in_seed    (s_tdata),
    .out_free   (out_free),
    .result     (result),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr_a(ram_raddr_a),
    .ram_raddr_b(ram_raddr_b),
    .ram_rdata_a(ram_rdata_a),
    .ram_rdata_b(ram_rdata_b)
  );

  mtg_table_ram #(
    .DEPTH (TABLE_LENGTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .raddr_b(ram_raddr_b),
    .rdata_a(ram_rdata_a),
    .rdata_b(ram_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      m_tdata <= result.word;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mtg_pkg::*;

  localparam int TABLE_LENGTH = 624;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_OFF_AFTER = 60;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic        op;
    logic [31:0] seed;
    bit          known;
    logic [31:0] word;
  } dir_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic        s_tuser = OP_DRAW;
  logic [31:0] s_tdata = 32'h0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  logic [31:0] mt_words [TABLE_LENGTH];
  int unsigned mt_pos;
  int unsigned table_wraps = 0;
  logic [31:0] pending_words [$];
  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  dir_item_t   directed_items [18];

  mersenne_twister_generator_top #(
    .TABLE_LENGTH(TABLE_LENGTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic void load_seed(input logic [31:0] seed);
    logic [31:0] prev;
    mt_words[0] = seed;
    for (int i = 1; i < TABLE_LENGTH; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = INIT_MULT * (prev ^ (prev >> INIT_SHIFT)) + 32'(i);
    end
    mt_pos = 0;
  endfunction

  function automatic void twist_words();
    logic [31:0] mix;
    for (int i = 0; i < TABLE_LENGTH; i++) begin
      mix = (mt_words[i] & UPPER_MASK) | (mt_words[(i + 1) % TABLE_LENGTH] & LOWER_MASK);
      mt_words[i] = mt_words[(i + SHIFT_M) % TABLE_LENGTH] ^ (mix >> 1)
                    ^ (mix[0] ? TWIST_MATRIX : 32'h0);
    end
  endfunction

  function automatic logic [31:0] next_mt_word();
    logic [31:0] w;
    if (mt_pos >= TABLE_LENGTH) mt_pos = 0;
    w = mt_words[mt_pos];
    mt_pos++;
    if (mt_pos >= TABLE_LENGTH) begin
      twist_words();
      mt_pos = 0;
      table_wraps++;
    end
    return w;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input logic op, input logic [31:0] seed, input bit known,
                           input logic [31:0] word, input bit calm);
    int gap;
    logic [31:0] w;
    gap = pick_gap(calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= seed;
    do @(posedge clk); while (!s_tready);
    if (op == OP_DRAW) begin
      w = next_mt_word();
      pending_words.push_back(known ? word : w);
    end else begin
      load_seed(seed);
    end
    items_sent++;
  endtask

  initial begin : result_side
    int stall_left;
    int calm_left;
    bit calm;
    bit held_off;
    logic [31:0] want;
    stall_left = 0;
    calm_left = 0;
    calm = 1'b0;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual random_word %h",
                   $time, m_tdata);
          mismatch_count++;
        end else begin
          want = pending_words.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: random_word expected %h actual %h", $time, want, m_tdata);
            mismatch_count++;
          end
        end
        words_checked++;
      end
      if (!held_off && words_checked >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (stall_left == 0 && !calm) stall_left = pick_gap(1'b0);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit calm;
    int burst;
    int unsigned wrap_goal;
    directed_items = '{
      '{OP_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_DRAW,   32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
      '{OP_DRAW,   32'h1234_5678, 1'b0, 32'h0},
      '{OP_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{OP_DRAW,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
      '{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0},
      '{OP_RESEED, 32'h0000_0001, 1'b0, 32'h0},
      '{OP_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0001},
      '{OP_DRAW,   32'h0000_0000, 1'b1, 32'h6C07_8966},
      '{OP_RESEED, 32'h8000_0000, 1'b0, 32'h0},
      '{OP_DRAW,   32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
      '{OP_RESEED, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_RESEED, 32'h5A5A_5A5A, 1'b0, 32'h0},
      '{OP_RESEED, 32'hA5A5_A5A5, 1'b0, 32'h0},
      '{OP_DRAW,   32'h5A5A_5A5A, 1'b1, 32'hA5A5_A5A5},
      '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0}
    };
    load_seed(32'h0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_items[i])
      send_item(directed_items[i].op, directed_items[i].seed, directed_items[i].known,
                directed_items[i].word, 1'b0);

    // short reseed-and-draw runs, with some unstructured noise
    while (items_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(4, 16);
        repeat (burst)
          send_item(($urandom_range(0, 3) == 0) ? OP_RESEED : OP_DRAW, $urandom(),
                    1'b0, 32'h0, calm);
      end else begin
        if ($urandom_range(0, 2) != 0) send_item(OP_RESEED, $urandom(), 1'b0, 32'h0, calm);
        burst = $urandom_range(1, 40);
        repeat (burst) send_item(OP_DRAW, $urandom(), 1'b0, 32'h0, calm);
      end
    end

    // one long run of draws across the index wrap and into the twisted table
    send_item(OP_RESEED, $urandom(), 1'b0, 32'h0, 1'b0);
    wrap_goal = table_wraps + 1;
    while (table_wraps < wrap_goal)
      send_item(OP_DRAW, $urandom(), 1'b0, 32'h0, ($urandom_range(0, 3) == 0));
    repeat (30) send_item(OP_DRAW, $urandom(), 1'b0, 32'h0, 1'b0);
    send_item(OP_RESEED, $urandom(), 1'b0, 32'h0, 1'b0);
    repeat (5) send_item(OP_DRAW, $urandom(), 1'b0, 32'h0, 1'b0);
    s_tvalid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (2 * TABLE_LENGTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mtg_pkg.sv
rtl/core/mtg_table_ram.sv
rtl/core/mtg_sequencer.sv
rtl/core/mersenne_twister_generator_top.sv
sim/tb_top.sv
